FILE: design/ddv_pkg.sv
`default_nettype none

package ddv_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_ORDER = 2'd2
    } status_t;

    // Configuration register indexes
    localparam logic REG_SIGNED_MODE = 1'b0;
    localparam logic REG_CAPACITY    = 1'b1;

    localparam int CFG_DATA_W    = 15;
    localparam logic [14:0] CAPACITY_RESET = 15'd16384;

    // Varint geometry
    localparam int MAX_CODE_BYTES = 10;
    localparam int NBYTES_W       = 4;

    // Front-to-back queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [63:0] value;
        logic        restart;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         code_byte;
        logic               last;
        status_t            status;
        logic               checkpoint;
        logic [13:0]        value_index;
        logic [14:0]        byte_total;
        logic signed [63:0] saved_delta;
    } out_item_t;

    typedef struct packed {
        logic        signed_mode;
        logic [14:0] capacity;
    } cfg_t;

    // One classified value waiting for serialization
    typedef struct packed {
        logic [63:0]         enc;
        logic [NBYTES_W-1:0] nbytes;
        status_t             status;
        logic                cp;
        logic [13:0]         idx;
        logic [14:0]         total;
        logic [63:0]         saved;
    } desc_t;

    // Zigzag map of a two's complement word
    function automatic logic [63:0] zigzag(input logic [63:0] x);
        return {x[62:0], 1'b0} ^ {64{x[63]}};
    endfunction

endpackage

`default_nettype wire

FILE: design/ddv_stream_if.sv
`default_nettype none

interface ddv_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/delta_of_delta_varint_encoder.sv
// A 4-entry queue between classifier and serializer absorbs long codes. A request is
// registered in the difference stage, classified and queued; its first code byte is
// then registered at the serializer output. No request is taken while the difference
// stage is busy or the queue is full. Code bytes leave the serializer at one per cycle
// while codes.ready is high. Reset (rst_n low, asynchronous) empties the pipeline and
// queue, clears the block history and sets signed_mode 0, capacity_bytes 16384.
`default_nettype none

module delta_of_delta_varint_encoder #(
    parameter int CHECKPOINT_STRIDE = 64,
    parameter int CAPACITY_WORDS    = 2048
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [ddv_pkg::CFG_DATA_W-1:0] cfg_data,
    ddv_stream_if.sink                          samples,
    ddv_stream_if.source                        codes
);

    ddv_pkg::cfg_t  cfg_reg, cfg_next;
    ddv_pkg::desc_t push_data;
    ddv_pkg::desc_t head;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    // Configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ddv_pkg::REG_SIGNED_MODE: cfg_next.signed_mode = cfg_data[0];
                ddv_pkg::REG_CAPACITY:    cfg_next.capacity    = cfg_data;
                default:                  cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.signed_mode <= 1'b0;
            cfg_reg.capacity    <= ddv_pkg::CAPACITY_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ddv_front #(
        .CHECKPOINT_STRIDE (CHECKPOINT_STRIDE),
        .CAPACITY_WORDS    (CAPACITY_WORDS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .samples    (samples),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    ddv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    ddv_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (queue_empty),
        .pop   (pop),
        .codes (codes)
    );

endmodule

`default_nettype wire

FILE: design/ddv_queue.sv
`default_nettype none

module ddv_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ddv_pkg::desc_t push_data,
    output logic               full,
    input  wire logic          pop,
    output ddv_pkg::desc_t     head,
    output logic               empty
);

    ddv_pkg::desc_t                   mem_reg [ddv_pkg::QUEUE_DEPTH];
    logic [ddv_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [ddv_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [ddv_pkg::QCNT_W-1:0]       count_reg, count_next;

    assign full  = (count_reg == ddv_pkg::QCNT_W'(ddv_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/ddv_front.sv
`default_nettype none

module ddv_front #(
    parameter int CHECKPOINT_STRIDE = 64,
    parameter int CAPACITY_WORDS    = 2048
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ddv_pkg::cfg_t cfg,
    ddv_stream_if.sink         samples,
    input  wire logic          queue_full,
    output logic               push,
    output ddv_pkg::desc_t     push_data
);

    localparam int HARD_CAP = CAPACITY_WORDS * 8;
    localparam int CAP_W    = $clog2(HARD_CAP + 1);
    localparam int CMP_W    = (CAP_W > 16) ? CAP_W : 16;
    localparam int PH_W     = (CHECKPOINT_STRIDE > 1) ? $clog2(CHECKPOINT_STRIDE) : 1;

    // Block history
    logic [63:0]     last_value_reg, last_value_next;
    logic [63:0]     prev_delta_reg, prev_delta_next;
    logic [14:0]     count_reg, count_next;
    logic [14:0]     bytes_reg, bytes_next;
    logic [PH_W-1:0] phase_reg, phase_next;

    // Difference stage
    logic        a_valid_reg, a_valid_next;
    logic [63:0] a_value_reg;
    logic [63:0] a_diff_reg;
    logic [63:0] a_dd_reg;
    logic        a_lt_reg;

    logic        take;
    logic [63:0] last_eff;
    logic [63:0] prev_eff;
    logic [64:0] diff_wide;
    logic [63:0] dd;

    logic                         ooo;
    logic [63:0]                  enc;
    logic [ddv_pkg::NBYTES_W-1:0] nbytes;
    logic [CMP_W-1:0]             cap_ext;
    logic [CMP_W-1:0]             cap_eff;
    logic [CMP_W-1:0]             sum;
    logic                         full;
    logic [14:0]                  count_inc;

    // One value in flight; a request is taken only while the queue is not full
    assign samples.ready = !a_valid_reg && !queue_full;
    assign take          = samples.valid && samples.ready;

    // Differences against the history, restart applied first
    always_comb
    begin
        last_eff  = samples.payload.restart ? 64'd0 : last_value_reg;
        prev_eff  = samples.payload.restart ? 64'd0 : prev_delta_reg;
        diff_wide = {1'b0, samples.payload.value} - {1'b0, last_eff};
        dd        = samples.payload.value - last_eff - prev_eff;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            a_value_reg <= samples.payload.value;
            a_diff_reg  <= diff_wide[63:0];
            a_dd_reg    <= dd;
            a_lt_reg    <= diff_wide[64];
        end
    end

    // Classification: code word, length, capacity
    always_comb
    begin
        ooo = !cfg.signed_mode && (count_reg != '0) && a_lt_reg;

        if (count_reg == '0)
        begin
            enc = a_value_reg;
        end
        else if (count_reg == 15'd1)
        begin
            enc = cfg.signed_mode ? ddv_pkg::zigzag(a_diff_reg) : a_diff_reg;
        end
        else
        begin
            enc = ddv_pkg::zigzag(a_dd_reg);
        end

        nbytes = ddv_pkg::NBYTES_W'(1);
        for (int k = 1; k < ddv_pkg::MAX_CODE_BYTES; k++)
        begin
            if ((enc >> (7 * k)) != 64'd0)
            begin
                nbytes = ddv_pkg::NBYTES_W'(k + 1);
            end
        end

        cap_ext = CMP_W'(cfg.capacity);
        if (cfg.capacity == '0 || cap_ext > CMP_W'(HARD_CAP))
        begin
            cap_eff = CMP_W'(HARD_CAP);
        end
        else
        begin
            cap_eff = cap_ext;
        end
        sum  = CMP_W'(bytes_reg) + CMP_W'(nbytes);
        full = (sum > cap_eff);
        count_inc = count_reg + 15'd1;
    end

    // Descriptor toward the serializer
    always_comb
    begin
        push = a_valid_reg;
        push_data.idx = count_reg[13:0];
        if (ooo || full)
        begin
            push_data.enc    = '0;
            push_data.nbytes = ddv_pkg::NBYTES_W'(1);
            push_data.status = ooo ? ddv_pkg::STATUS_ORDER : ddv_pkg::STATUS_FULL;
            push_data.cp     = 1'b0;
            push_data.total  = bytes_reg;
            push_data.saved  = prev_delta_reg;
        end
        else
        begin
            push_data.enc    = enc;
            push_data.nbytes = nbytes;
            push_data.status = ddv_pkg::STATUS_OK;
            push_data.cp     = (phase_reg == '0);
            push_data.total  = sum[14:0];
            push_data.saved  = (count_reg == '0) ? prev_delta_reg : a_diff_reg;
        end
    end

    // History update
    always_comb
    begin
        last_value_next = last_value_reg;
        prev_delta_next = prev_delta_reg;
        count_next      = count_reg;
        bytes_next      = bytes_reg;
        phase_next      = phase_reg;
        a_valid_next    = a_valid_reg;

        if (take)
        begin
            a_valid_next = 1'b1;
            if (samples.payload.restart)
            begin
                last_value_next = '0;
                prev_delta_next = '0;
                count_next      = '0;
                bytes_next      = '0;
                phase_next      = '0;
            end
        end
        else if (a_valid_reg)
        begin
            a_valid_next = 1'b0;
            if (!ooo && !full)
            begin
                last_value_next = a_value_reg;
                prev_delta_next = push_data.saved;
                bytes_next      = sum[14:0];
                count_next      = count_inc;
                if (count_inc == '0 || phase_reg == PH_W'(CHECKPOINT_STRIDE - 1))
                begin
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_value_reg <= '0;
            prev_delta_reg <= '0;
            count_reg      <= '0;
            bytes_reg      <= '0;
            phase_reg      <= '0;
            a_valid_reg    <= 1'b0;
        end
        else
        begin
            last_value_reg <= last_value_next;
            prev_delta_reg <= prev_delta_next;
            count_reg      <= count_next;
            bytes_reg      <= bytes_next;
            phase_reg      <= phase_next;
            a_valid_reg    <= a_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/ddv_back.sv
`default_nettype none

module ddv_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ddv_pkg::desc_t head,
    input  wire logic           empty,
    output logic                pop,
    ddv_stream_if.source        codes
);

    logic [ddv_pkg::NBYTES_W-1:0] k_reg, k_next;
    logic                         out_valid_reg, out_valid_next;
    ddv_pkg::out_item_t           out_reg, out_next;

    logic        load;
    logic        fin;
    logic [69:0] enc_pad;
    logic [6:0]  grp;

    assign codes.valid   = out_valid_reg;
    assign codes.payload = out_reg;

    // Byte selection from the head request
    always_comb
    begin
        load    = !empty && (!out_valid_reg || codes.ready);
        fin     = (k_reg == head.nbytes - ddv_pkg::NBYTES_W'(1));
        enc_pad = {6'd0, head.enc};
        grp     = '0;
        for (int j = 0; j < ddv_pkg::MAX_CODE_BYTES; j++)
        begin
            if (k_reg == ddv_pkg::NBYTES_W'(j))
            begin
                grp = enc_pad[7 * j +: 7];
            end
        end
    end

    // Output register and byte counter
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next       = 1'b1;
            out_next.code_byte   = {!fin, grp};
            out_next.last        = fin;
            out_next.status      = head.status;
            out_next.checkpoint  = fin && head.cp;
            out_next.value_index = head.idx;
            out_next.byte_total  = head.total;
            out_next.saved_delta = head.saved;
            if (fin)
            begin
                pop    = 1'b1;
                k_next = '0;
            end
            else
            begin
                k_next = k_reg + 1'b1;
            end
        end
        else if (codes.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

`default_nettype wire

FILE: design/ddv_checker.sv
`default_nettype none

module ddv_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  out_code,
    input wire logic        out_last,
    input wire logic [1:0]  out_status,
    input wire logic        out_checkpoint
);

    // A pending result stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn while stalled");

    // Continuation bit is set on every byte but the final one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_code[7] == !out_last))
        else $error("continuation bit disagrees with last");

    // Rejected values give one empty final byte and no checkpoint
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != ddv_pkg::STATUS_OK)
            |-> out_last && (out_code == 8'd0) && !out_checkpoint)
        else $error("malformed reject result");

    // A request is not taken while the difference stage is busy with the one before
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while difference stage busy");

endmodule

bind delta_of_delta_varint_encoder ddv_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (samples.valid),
    .in_ready       (samples.ready),
    .out_valid      (codes.valid),
    .out_ready      (codes.ready),
    .out_code       (codes.payload.code_byte),
    .out_last       (codes.payload.last),
    .out_status     (codes.payload.status),
    .out_checkpoint (codes.payload.checkpoint)
);

`default_nettype wire
